>>> src/md5_block_compress_top_macros.svh
// Assertion macros for the MD5 block compression checker.
// No dependencies; every user must have clk and rst_n in scope.
`ifndef MD5_BLOCK_COMPRESS_TOP_MACROS_SVH
`define MD5_BLOCK_COMPRESS_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define MD5BC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define MD5BC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/md5bc_pkg.sv
// Shared types, constants and round helpers for the MD5 block compressor.
// No dependencies.
package md5bc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned BlkWords = 16;

  localparam logic [WordW-1:0] IV_A = 32'h67452301;
  localparam logic [WordW-1:0] IV_B = 32'hefcdab89;
  localparam logic [WordW-1:0] IV_C = 32'h98badcfe;
  localparam logic [WordW-1:0] IV_D = 32'h10325476;

  localparam logic [3:0] LAST_SLOT = 4'd15;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  localparam logic [1:0] PHASE_F = 2'd0;
  localparam logic [1:0] PHASE_G = 2'd1;
  localparam logic [1:0] PHASE_H = 2'd2;
  localparam logic [1:0] PHASE_I = 2'd3;

  localparam logic [WordW-1:0] ROUND_K [Rounds] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic [WordW-1:0] message_word;
    logic             first_block;
  } in_data_t;

  typedef struct packed {
    logic [WordW-1:0] digest_a;
    logic [WordW-1:0] digest_b;
    logic [WordW-1:0] digest_c;
    logic [WordW-1:0] digest_d;
  } out_data_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ROUND = 2'd1,
    ST_FINAL = 2'd2
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       take_word;   // store the accepted word
    logic       start;       // load working words, prefetch round 0 operand
    logic       round;       // run one round
    logic [5:0] round_idx;
    logic       finish;      // fold into chain, load result register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last_slot;  // next word fills slot 15 unless flagged first_block
    logic out_full;   // result register still holds an untaken result
  } dp_stat_t;

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] idx;
    unique case (r[5:4])
      PHASE_F: idx = r[3:0];
      PHASE_G: idx = 4'(r[3:0] * 4'd5 + 4'd1);
      PHASE_H: idx = 4'(r[3:0] * 4'd3 + 4'd5);
      PHASE_I: idx = 4'(r[3:0] * 4'd7);
      default: idx = r[3:0];
    endcase
    return idx;
  endfunction

  function automatic logic [WordW-1:0] round_fn(input logic [1:0] phase,
                                                input logic [WordW-1:0] b,
                                                input logic [WordW-1:0] c,
                                                input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    unique case (phase)
      PHASE_F: f = (b & c) | (~b & d);
      PHASE_G: f = (d & b) | (~d & c);
      PHASE_H: f = b ^ c ^ d;
      PHASE_I: f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic logic [WordW-1:0] rotl32(input logic [WordW-1:0] v,
                                              input logic [4:0] n);
    logic [2*WordW-1:0] dbl;
    dbl = {v, v} << n;
    return dbl[2*WordW-1:WordW];
  endfunction

endpackage

>>> src/md5bc_ctrl.sv
// Sequencer for the MD5 block compressor: word intake, 64 rounds, final fold.
// Depends on md5bc_pkg.
module md5bc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_first,
  output logic                in_ready,
  input  md5bc_pkg::dp_stat_t stat,
  output md5bc_pkg::dp_cmd_t  cmd
);
  import md5bc_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] round_r, round_nxt;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    in_ready  = 1'b0;
    accept    = 1'b0;
    cmd       = '0;
    cmd.round_idx = round_r;
    unique case (state_r)
      ST_IDLE: begin
        // hold the closing word while the previous result is untaken
        in_ready       = !(stat.last_slot && stat.out_full);
        accept         = in_valid && in_ready;
        cmd.take_word  = accept;
        if (accept && !in_first && stat.last_slot) begin
          cmd.start = 1'b1;
          round_nxt = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        round_nxt = round_r + 6'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/md5bc_datapath.sv
// Datapath of the MD5 block compressor: block buffer, chaining and working
// words, one-round logic and result register. Depends on md5bc_pkg.
module md5bc_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  md5bc_pkg::in_data_t  in_data,
  input  md5bc_pkg::dp_cmd_t   cmd,
  output md5bc_pkg::dp_stat_t  stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output md5bc_pkg::out_data_t out_data
);
  import md5bc_pkg::*;

  logic [WordW-1:0] blk_r [BlkWords];
  logic [3:0]       count_r, count_nxt;
  logic [3:0]       slot;
  logic [WordW-1:0] chain_a_r, chain_b_r, chain_c_r, chain_d_r;
  logic [WordW-1:0] wa_r, wb_r, wc_r, wd_r;
  logic [WordW-1:0] km_r;
  logic [5:0]       km_round;
  logic [WordW-1:0] sum_t, b_new;
  logic [WordW-1:0] fold_a, fold_b, fold_c, fold_d;
  out_data_t        out_r;
  logic             out_valid_r;

  assign slot = in_data.first_block ? 4'd0 : count_r;

  always_comb begin
    count_nxt = count_r;
    if (cmd.take_word) begin
      count_nxt = (slot == LAST_SLOT) ? 4'd0 : slot + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_word) begin
      blk_r[slot] <= in_data.message_word;
    end
  end

  // Round operand K + M is registered in the cycle before its round to shorten the round path.
  assign km_round = cmd.start ? 6'd0 : cmd.round_idx + 6'd1;
  assign sum_t    = wa_r + round_fn(cmd.round_idx[5:4], wb_r, wc_r, wd_r) + km_r;
  assign b_new    = wb_r + rotl32(sum_t, ROT_AMT[{cmd.round_idx[5:4], cmd.round_idx[1:0]}]);

  assign fold_a = chain_a_r + wa_r;
  assign fold_b = chain_b_r + wb_r;
  assign fold_c = chain_c_r + wc_r;
  assign fold_d = chain_d_r + wd_r;

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.round) begin
      km_r <= ROUND_K[km_round] + blk_r[msg_index(km_round)];
    end
    if (cmd.start) begin
      wa_r <= chain_a_r;
      wb_r <= chain_b_r;
      wc_r <= chain_c_r;
      wd_r <= chain_d_r;
    end else if (cmd.round) begin
      wa_r <= wd_r;
      wb_r <= b_new;
      wc_r <= wb_r;
      wd_r <= wc_r;
    end
    if (cmd.finish) begin
      out_r <= '{digest_a: fold_a, digest_b: fold_b, digest_c: fold_c, digest_d: fold_d};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      chain_a_r   <= IV_A;
      chain_b_r   <= IV_B;
      chain_c_r   <= IV_C;
      chain_d_r   <= IV_D;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.take_word && in_data.first_block) begin
        chain_a_r <= IV_A;
        chain_b_r <= IV_B;
        chain_c_r <= IV_C;
        chain_d_r <= IV_D;
      end else if (cmd.finish) begin
        chain_a_r <= fold_a;
        chain_b_r <= fold_b;
        chain_c_r <= fold_c;
        chain_d_r <= fold_d;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.last_slot = (count_r == LAST_SLOT);
  assign stat.out_full  = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule

>>> src/md5_block_compress_top.sv
// MD5 block compressor, top level: handshake ports, sequencer and datapath.
// Depends on md5bc_pkg, md5bc_ctrl and md5bc_datapath.
//
// One input transaction carries a 32-bit message word (little-endian packed)
// and a first_block flag. Words fill a 16-word block buffer; first_block
// reloads the standard MD5 initial chaining values and restarts the block at
// word 0, dropping any partly filled block. The sixteenth word starts the
// compression: its accept cycle also prefetches the round-0 operand, the shared
// round unit then runs one MD5 round per cycle for all 64 rounds, and a final
// step adds the working words into the chaining state and loads the result
// register. in_ready stays low during the rounds and the final fold. The
// result register lets intake of the next block proceed while a digest waits
// to be taken; only a word offered for slot 15 of the next block (the closing
// word, or a flagged word arriving there) waits until that digest is gone.
// Each completed block yields one output transaction with chaining words A-D.
// Padding and length words are the feeder's job.
module md5_block_compress_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  md5bc_pkg::in_data_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output md5bc_pkg::out_data_t out_data
);
  import md5bc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence intake, rounds and the final fold.
  md5bc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_first (in_data.first_block),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the block, chaining state and result register.
  md5bc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> src/md5bc_checker.sv
// Port-level checks for the MD5 block compressor, bound to the top level.
// Depends on md5bc_pkg and md5_block_compress_top_macros.svh.
`include "md5_block_compress_top_macros.svh"

module md5bc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input md5bc_pkg::in_data_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input md5bc_pkg::out_data_t out_data
);
  import md5bc_pkg::*;

  // A stalled result stays offered.
  `MD5BC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its digest.
  `MD5BC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed while stalled")

  // A new result follows a compression during which intake was closed.
  `MD5BC_ASSERT_NOW(a_busy_before_result, $rose(out_valid) && !$past(out_valid, 1), !$past(in_ready, 1) && !$past(in_ready, 2), "result without closed intake")

  // The intake was already closed at the first round and still closed midway through the rounds.
  `MD5BC_ASSERT_NOW(a_round_span, $rose(out_valid), !$past(in_ready, 65) && !$past(in_ready, 33), "compression shorter than 64 rounds")

endmodule

bind md5_block_compress_top md5bc_checker u_md5bc_chk (.*);
